>>> src/rsd_pkg.sv
package rsd_pkg;

    // Field widths of the stream words.
    localparam int BYTE_W    = 8;
    localparam int DIM_W     = 16;
    localparam int COLOR_W   = 16;
    localparam int STATUS_W  = 2;
    localparam int OUT_DATA_W = 64;

    // Colors are masked to this many bits, at most sixteen.
    localparam int COLOR_BITS = 16;
    localparam logic [COLOR_W-1:0] COLOR_MASK =
        COLOR_W'((33'd1 << COLOR_BITS) - 33'd1);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // Input word kinds, carried in tuser.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_TAKEN    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PIXEL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_PIXEL = 2'd3;

    // Special byte values of the header text.
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

    // One classified input word as it waits in the queue.
    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data_byte;
        logic              is_digit;
        logic [3:0]        digit;
        logic              is_newline;
    } item_t;

endpackage

>>> src/rsd_front.sv
module rsd_front (
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [rsd_pkg::BYTE_W-1:0] s_axis_tdata,  // data_byte
    input  logic                       s_axis_tuser,  // op
    input  logic                       queue_full,
    output logic                       push,
    output rsd_pkg::item_t             push_item
);

    logic [rsd_pkg::BYTE_W-1:0] digit_val;

    // Take a word whenever the queue has room.
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    // Classify the byte so that the back only selects.
    assign digit_val = s_axis_tdata - rsd_pkg::CHAR_ZERO;

    always_comb begin
        push_item.op         = s_axis_tuser;
        push_item.data_byte  = s_axis_tdata;
        push_item.is_digit   = (s_axis_tdata >= rsd_pkg::CHAR_ZERO) &&
                               (s_axis_tdata <= rsd_pkg::CHAR_NINE);
        push_item.digit      = digit_val[3:0];
        push_item.is_newline = (s_axis_tdata == rsd_pkg::CHAR_NEWLINE);
    end

endmodule

>>> src/rsd_queue.sv
module rsd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rsd_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rsd_pkg::item_t head_item
);

    rsd_pkg::item_t                   entry_reg [rsd_pkg::QUEUE_DEPTH];
    logic [rsd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rsd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rsd_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    localparam logic [rsd_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        rsd_pkg::QUEUE_PTR_W'(rsd_pkg::QUEUE_DEPTH - 1);
    localparam logic [rsd_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
        rsd_pkg::QUEUE_CNT_W'(rsd_pkg::QUEUE_DEPTH);

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The fill count never goes past the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("queue fill count exceeds depth");

    // A pop is only issued on a queue that holds a word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

>>> src/rsd_back.sv
module rsd_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                head_valid,
    input  rsd_pkg::item_t                      head_item,
    output logic                                pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_color, image_width, image_height, background_color
    output logic [rsd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [rsd_pkg::STATUS_W-1:0]        m_axis_tuser,  // status
    output logic                                m_axis_tlast   // last_pixel
);

    // Parse phase codes.
    localparam logic [2:0] PH_WIDTH_FIRST  = 3'd0;
    localparam logic [2:0] PH_WIDTH_REST   = 3'd1;
    localparam logic [2:0] PH_HEIGHT_FIRST = 3'd2;
    localparam logic [2:0] PH_HEIGHT_REST  = 3'd3;
    localparam logic [2:0] PH_SKIP         = 3'd4;
    localparam logic [2:0] PH_RECORD       = 3'd5;

    localparam logic [16:0] FULL_RUN = 17'h10000;

    typedef struct packed {
        logic [rsd_pkg::DIM_W-1:0] value;
        logic                      ended;
        logic                      done;
    } dim_res_t;

    logic [2:0]                  phase_reg, phase_next;
    logic                        ended_reg, ended_next;
    logic [rsd_pkg::DIM_W-1:0]   width_reg, width_next;
    logic [rsd_pkg::DIM_W-1:0]   height_reg, height_next;
    logic [rsd_pkg::COLOR_W-1:0] bg_reg, bg_next;
    logic [1:0]                  idx_reg, idx_next;
    logic [31:0]                 buf_reg, buf_next;
    logic                        ready_reg, ready_next;
    logic [16:0]                 run_reg, run_next;
    logic [rsd_pkg::COLOR_W-1:0] color_reg, color_next;
    logic [rsd_pkg::DIM_W-1:0]   col_reg, col_next;
    logic [rsd_pkg::DIM_W-1:0]   row_reg, row_next;

    logic                        out_valid_reg;
    logic [rsd_pkg::STATUS_W-1:0] out_status_reg, status_next;
    logic [rsd_pkg::COLOR_W-1:0] out_color_reg, pix_color_next;
    logic                        out_last_reg, last_next;
    logic [rsd_pkg::DIM_W-1:0]   out_width_reg, out_height_reg;
    logic [rsd_pkg::COLOR_W-1:0] out_bg_reg;

    dim_res_t                    dim_w, dim_w0, dim_h, dim_h0;
    logic [16:0]                 run_cur;
    logic [rsd_pkg::COLOR_W-1:0] color_cur;
    logic [rsd_pkg::DIM_W-1:0]   col_inc, row_inc;

    // One header byte against a dimension value.
    function automatic dim_res_t dim_step(input logic [rsd_pkg::DIM_W-1:0] value,
                                          input logic ended,
                                          input rsd_pkg::item_t it);
        dim_res_t r;
        r.value = value;
        r.ended = ended;
        r.done  = 1'b0;
        if (!ended && it.is_digit) begin
            r.value = (value << 3) + (value << 1) + {12'd0, it.digit};
        end else begin
            r.ended = 1'b1;
        end
        if (it.is_newline) begin
            r.ended = 1'b0;
            r.done  = 1'b1;
        end
        return r;
    endfunction

    // A word is executed whenever the output register is free or drains.
    assign pop = head_valid && (!out_valid_reg || m_axis_tready);

    assign dim_w  = dim_step(width_reg, ended_reg, head_item);
    assign dim_w0 = dim_step('0, 1'b0, head_item);
    assign dim_h  = dim_step(height_reg, ended_reg, head_item);
    assign dim_h0 = dim_step('0, 1'b0, head_item);

    assign col_inc = col_reg + 1'b1;
    assign row_inc = row_reg + 1'b1;

    // Next state for the word at the head of the queue.
    always_comb begin
        phase_next     = phase_reg;
        ended_next     = ended_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        bg_next        = bg_reg;
        idx_next       = idx_reg;
        buf_next       = buf_reg;
        ready_next     = ready_reg;
        run_next       = run_reg;
        color_next     = color_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        status_next    = rsd_pkg::ST_TAKEN;
        pix_color_next = '0;
        last_next      = 1'b0;
        run_cur        = run_reg;
        color_cur      = color_reg;

        if (head_item.op == rsd_pkg::OP_BYTE) begin
            unique case (phase_reg)
                PH_WIDTH_REST: begin
                    width_next = dim_w.value;
                    ended_next = dim_w.ended;
                    if (dim_w.done) begin
                        phase_next = PH_HEIGHT_FIRST;
                    end
                end
                PH_HEIGHT_FIRST: begin
                    height_next = dim_h0.value;
                    ended_next  = dim_h0.ended;
                    phase_next  = dim_h0.done ? PH_SKIP : PH_HEIGHT_REST;
                end
                PH_HEIGHT_REST: begin
                    height_next = dim_h.value;
                    ended_next  = dim_h.ended;
                    if (dim_h.done) begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    ended_next = 1'b0;
                    idx_next   = '0;
                    buf_next   = '0;
                    ready_next = 1'b0;
                    run_next   = '0;
                    color_next = '0;
                    col_next   = '0;
                    row_next   = '0;
                    phase_next = (width_reg != '0 && height_reg != '0) ?
                                 PH_RECORD : PH_WIDTH_FIRST;
                end
                PH_RECORD: begin
                    if (ready_reg) begin
                        status_next = rsd_pkg::ST_REFUSED;
                    end else begin
                        case (idx_reg)
                            2'd0:    buf_next[7:0]   = buf_reg[7:0]   | head_item.data_byte;
                            2'd1:    buf_next[15:8]  = buf_reg[15:8]  | head_item.data_byte;
                            2'd2:    buf_next[23:16] = buf_reg[23:16] | head_item.data_byte;
                            default: buf_next[31:24] = buf_reg[31:24] | head_item.data_byte;
                        endcase
                        idx_next = idx_reg + 1'b1;
                        if (idx_reg == 2'd3) begin
                            ready_next = 1'b1;
                        end
                    end
                end
                default: begin
                    width_next = dim_w0.value;
                    ended_next = dim_w0.ended;
                    phase_next = dim_w0.done ? PH_HEIGHT_FIRST : PH_WIDTH_REST;
                end
            endcase
        end else if (phase_reg != PH_RECORD || (run_reg == '0 && !ready_reg)) begin
            status_next = rsd_pkg::ST_NO_PIXEL;
        end else begin
            // Load the buffered record when no run is in progress.
            if (run_reg == '0) begin
                run_cur    = (buf_reg[15:0] == '0) ? FULL_RUN : {1'b0, buf_reg[15:0]};
                color_cur  = buf_reg[31:16] & rsd_pkg::COLOR_MASK;
                buf_next   = '0;
                ready_next = 1'b0;
                if (row_reg == '0 && col_reg == '0) begin
                    bg_next = color_cur;
                end
            end
            status_next    = rsd_pkg::ST_PIXEL;
            pix_color_next = color_cur;
            color_next     = color_cur;
            run_next       = run_cur - 1'b1;
            col_next       = col_inc;
            if (col_inc == width_reg) begin
                col_next = '0;
                row_next = row_inc;
                // End of frame drops any pending record and run.
                if (row_inc == height_reg) begin
                    last_next  = 1'b1;
                    phase_next = PH_WIDTH_FIRST;
                    ended_next = 1'b0;
                    idx_next   = '0;
                    buf_next   = '0;
                    ready_next = 1'b0;
                    run_next   = '0;
                    color_next = '0;
                    col_next   = '0;
                    row_next   = '0;
                end
            end
        end
    end

    // Decoder state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_WIDTH_FIRST;
            ended_reg  <= 1'b0;
            width_reg  <= 16'd136;
            height_reg <= 16'd136;
            bg_reg     <= '0;
            idx_reg    <= '0;
            buf_reg    <= '0;
            ready_reg  <= 1'b0;
            run_reg    <= '0;
            color_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (pop) begin
            phase_reg  <= phase_next;
            ended_reg  <= ended_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            bg_reg     <= bg_next;
            idx_reg    <= idx_next;
            buf_reg    <= buf_next;
            ready_reg  <= ready_next;
            run_reg    <= run_next;
            color_reg  <= color_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (pop) begin
            out_status_reg <= status_next;
            out_color_reg  <= pix_color_next;
            out_last_reg   <= last_next;
            out_width_reg  <= width_next;
            out_height_reg <= height_next;
            out_bg_reg     <= bg_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_bg_reg, out_height_reg, out_width_reg, out_color_reg};

    // A full record buffer always sits on a record boundary.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> (idx_reg == 2'd0))
        else $error("record ready with partial byte index");

    // A run in progress only exists in the record phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg != '0) |-> (phase_reg == PH_RECORD))
        else $error("run left over outside the record phase");

    // The frame end flag only comes with a delivered pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_last_reg) |-> (out_status_reg == rsd_pkg::ST_PIXEL))
        else $error("last pixel flag without a pixel");

endmodule

>>> src/rle_splash_decoder_unit.sv
// Path: an accepted word is written into the queue, and the back-end decoder executes it
// into the output register, which offers its result on the m_ side. Throughput: one word
// per cycle unless m_axis_tready stalls, input bytes and pixel requests alike; each word is
// one step of the back-end decoder, fed from a two-entry queue behind the input port.
// Reset: aresetn is synchronous and active low; it empties the queue and output register,
// sets width and height to 136, background to zero and restarts header parsing.
module rle_splash_decoder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [rsd_pkg::BYTE_W-1:0]          s_axis_tdata,  // data_byte
    input  logic                                s_axis_tuser,  // op
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_color, image_width, image_height, background_color
    output logic [rsd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [rsd_pkg::STATUS_W-1:0]        m_axis_tuser,  // status
    output logic                                m_axis_tlast   // last_pixel
);

    logic           push;
    logic           queue_full;
    logic           pop;
    logic           head_valid;
    rsd_pkg::item_t push_item;
    rsd_pkg::item_t head_item;

    // Input side: accept and classify words.
    rsd_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    // Short queue between the two halves.
    rsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Decoder state and result register.
    rsd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> tb/tb_rle_splash_decoder_unit.sv
module tb_rle_splash_decoder_unit;
    import rsd_pkg::*;

    // Decoder phases, in the order the stream walks through them.
    typedef enum logic [2:0] {
        PH_WIDTH_FIRST,
        PH_WIDTH_REST,
        PH_HEIGHT_FIRST,
        PH_HEIGHT_REST,
        PH_SKIP,
        PH_RECORDS
    } phase_e;

    // One expected output word, field by field.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COLOR_W-1:0]  color;
        logic                last_px;
        logic [DIM_W-1:0]    img_w;
        logic [DIM_W-1:0]    img_h;
        logic [COLOR_W-1:0]  bg;
    } pixel_word_t;

    localparam int QUIET_LIMIT = 1000;

    // Tracks the decoder state and queues the word each accepted input should produce.
    class splash_tracker;
        phase_e             phase;
        bit                 digits_done;
        logic [DIM_W-1:0]   img_w;
        logic [DIM_W-1:0]   img_h;
        logic [COLOR_W-1:0] bg;
        logic [1:0]         rec_idx;
        logic [31:0]        rec_buf;
        bit                 rec_ready;
        logic [16:0]        run_left;
        logic [COLOR_W-1:0] run_color;
        logic [DIM_W-1:0]   col;
        logic [DIM_W-1:0]   row;
        pixel_word_t        expected_words[$];
        int unsigned        errors;

        function new();
            img_w = 16'd136;
            img_h = 16'd136;
            bg = '0;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            phase = PH_WIDTH_FIRST;
            digits_done = 0;
            rec_idx = '0;
            rec_buf = '0;
            rec_ready = 0;
            run_left = '0;
            run_color = '0;
            col = '0;
            row = '0;
        endfunction

        // Adds one header byte to the width or the height; true at the newline.
        function bit feed_dim(bit is_height, logic [BYTE_W-1:0] b);
            logic [DIM_W-1:0] v;
            logic [DIM_W-1:0] dig;
            v = is_height ? img_h : img_w;
            dig = {8'd0, b} - {8'd0, CHAR_ZERO};
            if (!digits_done && b >= CHAR_ZERO && b <= CHAR_NINE) begin
                v = v * 16'd10 + dig;
            end else begin
                digits_done = 1;
            end
            if (is_height) img_h = v;
            else img_w = v;
            if (b == CHAR_NEWLINE) begin
                digits_done = 0;
                return 1;
            end
            return 0;
        endfunction

        function logic [STATUS_W-1:0] take_byte(logic [BYTE_W-1:0] b);
            case (phase)
                PH_WIDTH_REST: begin
                    if (feed_dim(0, b)) phase = PH_HEIGHT_FIRST;
                end
                PH_HEIGHT_FIRST: begin
                    img_h = '0;
                    digits_done = 0;
                    phase = PH_HEIGHT_REST;
                    if (feed_dim(1, b)) phase = PH_SKIP;
                end
                PH_HEIGHT_REST: begin
                    if (feed_dim(1, b)) phase = PH_SKIP;
                end
                PH_SKIP: begin
                    // A zero dimension sends the stream straight back to the width.
                    clear_frame();
                    if (img_w != 0 && img_h != 0) phase = PH_RECORDS;
                end
                PH_RECORDS: begin
                    if (rec_ready) return ST_REFUSED;
                    rec_buf = rec_buf | ({24'd0, b} << (8 * rec_idx));
                    rec_idx = rec_idx + 2'd1;
                    if (rec_idx == 0) rec_ready = 1;
                end
                default: begin
                    img_w = '0;
                    digits_done = 0;
                    phase = PH_WIDTH_REST;
                    if (feed_dim(0, b)) phase = PH_HEIGHT_FIRST;
                end
            endcase
            return ST_TAKEN;
        endfunction

        // Notes an accepted input word and queues its expected output word.
        function void take_word(logic op, logic [BYTE_W-1:0] b);
            pixel_word_t r;
            r = '0;
            if (op == OP_BYTE) begin
                r.status = take_byte(b);
            end else if (phase != PH_RECORDS || (run_left == 0 && !rec_ready)) begin
                r.status = ST_NO_PIXEL;
            end else begin
                // Load the buffered record when the current run is used up.
                if (run_left == 0) begin
                    run_left = (rec_buf[15:0] == 0) ? 17'h10000 : {1'b0, rec_buf[15:0]};
                    run_color = rec_buf[31:16] & COLOR_MASK;
                    rec_buf = '0;
                    rec_ready = 0;
                    if (row == 0 && col == 0) bg = run_color;
                end
                r.status = ST_PIXEL;
                r.color = run_color;
                run_left = run_left - 17'd1;
                col = col + 16'd1;
                if (col == img_w) begin
                    col = '0;
                    row = row + 16'd1;
                    if (row == img_h) begin
                        r.last_px = 1;
                        clear_frame();
                    end
                end
            end
            r.img_w = img_w;
            r.img_h = img_h;
            r.bg = bg;
            expected_words.push_back(r);
        endfunction

        // Compares one output word with the oldest expected word.
        function void check_word(logic [STATUS_W-1:0] st, logic [OUT_DATA_W-1:0] data,
                                 logic lst);
            pixel_word_t e;
            logic [OUT_DATA_W-1:0] e_data;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output word: status %0d data %h last %0d",
                             st, data, lst);
                return;
            end
            e = expected_words.pop_front();
            e_data = {e.bg, e.img_h, e.img_w, e.color};
            if (st !== e.status || data !== e_data || lst !== e.last_px) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch (expected/actual): status %0d/%0d color %h/%h last %0d/%0d",
                             e.status, st, e.color, data[15:0], e.last_px, lst);
                    $display("  width %0d/%0d height %0d/%0d background %h/%h",
                             e.img_w, data[31:16], e.img_h, data[47:32],
                             e.bg, data[63:48]);
                end
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  m_axis_tlast;

    splash_tracker tracker;
    bit            idle_on = 1;
    int unsigned   n_words = 0;
    int unsigned   stall_left = 0;
    int unsigned   quiet_cycles = 0;

    rle_splash_decoder_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial aclk = 0;
    always #10 aclk = ~aclk;

    // Output side: random stall bursts of random length while idling is on.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    // Check every output word as it is accepted.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            tracker.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // Watchdog on cycles in which no word moves on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("rle_splash_decoder_unit test failed");
                $finish;
            end
        end
    end

    // Drives one input word and waits for it to be accepted.
    task automatic send_word(input logic op, input logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= b;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        tracker.take_word(op, b);
        n_words++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_word(OP_BYTE, s[i]);
    endtask

    // Header bytes, with a stray pixel request now and then.
    task automatic send_header_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(0, 11) == 0) send_word(OP_PIXEL, 8'($urandom));
        send_word(OP_BYTE, b);
    endtask

    // One dimension line: digits unless no_digits is set, some trailing junk, and the newline.
    task automatic send_dim_line(input int unsigned val, input bit no_digits);
        string s;
        logic [BYTE_W-1:0] c;
        int n_junk;
        if (!no_digits) begin
            s = $sformatf("%0d", val);
            for (int i = 0; i < s.len(); i++) send_header_byte(s[i]);
        end
        n_junk = $urandom_range(0, 2);
        for (int i = 0; i < n_junk; i++) begin
            do c = 8'($urandom);
            while (c == CHAR_NEWLINE || (i == 0 && c >= CHAR_ZERO && c <= CHAR_NINE));
            send_header_byte(c);
        end
        send_header_byte(CHAR_NEWLINE);
    endtask

    // Picks a dimension: mostly tiny, sometimes zero or past sixteen bits.
    task automatic pick_dim(output int unsigned val, output bit no_digits);
        int r;
        r = $urandom_range(0, 19);
        no_digits = (r == 0);
        if (r <= 1) val = 0;
        else if (r == 2) val = 65536 * $urandom_range(1, 3) + $urandom_range(1, 3);
        else val = $urandom_range(1, 4);
    endtask

    // One frame: header, skip byte, then records and pixel requests until the frame ends.
    task automatic send_frame();
        int unsigned w;
        int unsigned h;
        bit w_nd;
        bit h_nd;
        int r;
        logic [15:0] cnt;
        logic [31:0] rec;
        rec = '0;
        pick_dim(w, w_nd);
        pick_dim(h, h_nd);
        send_dim_line(w, w_nd);
        send_dim_line(h, h_nd);
        send_header_byte(8'($urandom));
        while (tracker.phase == PH_RECORDS) begin
            r = $urandom_range(0, 15);
            if (r == 0) begin
                send_word(1'($urandom_range(0, 1)), 8'($urandom));
            end else if ((tracker.run_left != 0 || tracker.rec_ready) && r > 3) begin
                send_word(OP_PIXEL, 8'($urandom));
            end else begin
                if (tracker.rec_idx == 0 && !tracker.rec_ready) begin
                    r = $urandom_range(0, 15);
                    if (r == 0) cnt = '0;
                    else if (r == 1) cnt = 16'($urandom);
                    else cnt = 16'($urandom_range(1, 4));
                    rec = {16'($urandom), cnt};
                end
                send_word(OP_BYTE, rec[8 * tracker.rec_idx +: 8]);
            end
        end
    endtask

    initial begin
        tracker = new();
        aresetn = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_BYTE;
        m_axis_tready = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Pixel request before any header.
        send_word(OP_PIXEL, 8'h00);
        // Width past sixteen bits with a digit after junk; height one.
        send_text("65538x9\n");
        send_text("1\n");
        send_word(OP_BYTE, 8'hFF);
        // No record yet, then a zero-count record and a byte refused while it waits.
        send_word(OP_PIXEL, 8'h00);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'hAA);
        send_word(OP_PIXEL, 8'h00);
        send_word(OP_PIXEL, 8'h00);
        // Header lines without digits give a zero frame.
        send_text("\n\n");
        send_word(OP_BYTE, 8'h5A);

        // Random frames until the word budget is spent; the tail runs without idling.
        while (n_words < 1300) begin
            if (n_words >= 1100) idle_on = 0;
            send_frame();
        end

        s_axis_tvalid <= 0;
        while (tracker.expected_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (tracker.errors == 0 && tracker.expected_words.size() == 0) begin
            $display("rle_splash_decoder_unit test passed");
        end else begin
            $display("rle_splash_decoder_unit test failed");
        end
        $finish;
    end

endmodule
